// ===== hw/rtl/log_window_convolution_assert.svh =====
// Assertion macros shared by the log window convolution RTL.
`ifndef LOG_WINDOW_CONVOLUTION_ASSERT_SVH
`define LOG_WINDOW_CONVOLUTION_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define LWC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define LWC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LWC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`define LWC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/lwc_pkg.sv =====
// Shared constants and types of the log window convolution block.
`timescale 1ns / 1ps

package lwc_pkg;

  localparam int PIX_W     = 8;
  localparam int COEF_W    = 24;
  localparam int IDX_W     = 5;
  localparam int ROW_W     = 12;
  localparam int OUT_COL_W = 10;
  localparam int CFG_W_W   = 11;
  localparam int CFG_H_W   = 12;
  localparam int PROD_W    = PIX_W + COEF_W + 1;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam int DEF_WINDOW_SIZE = 5;
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_FRAC_BITS   = 12;

  localparam logic [CFG_W_W-1:0] WIDTH_RESET  = CFG_W_W'(640);
  localparam logic [CFG_H_W-1:0] HEIGHT_RESET = CFG_H_W'(480);

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  localparam logic REQ_COEF  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic             advance;
    logic             shift;
    logic             coef_wr;
    logic [IDX_W-1:0] coef_index;
  } ctrl_t;

  typedef struct packed {
    logic                 last;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
  } tag_t;

endpackage

// ===== hw/rtl/lwc_req_if.sv =====
// Request channel: coefficient loads and pixel samples.
`timescale 1ns / 1ps

interface lwc_req_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic [lwc_pkg::IDX_W-1:0]          coef_index;
  logic signed [lwc_pkg::COEF_W-1:0]  coef_value;
  logic [lwc_pkg::PIX_W-1:0]          pixel_in;

  modport source (
    output valid, req_type, coef_index, coef_value, pixel_in,
    input  ready
  );

  modport sink (
    input  valid, req_type, coef_index, coef_value, pixel_in,
    output ready
  );
endinterface

// ===== hw/rtl/lwc_res_if.sv =====
// Result channel: filtered pixels with their window centre position.
`timescale 1ns / 1ps

interface lwc_res_if;
  logic                            valid;
  logic                            ready;
  logic [lwc_pkg::PIX_W-1:0]       pixel_out;
  logic [lwc_pkg::ROW_W-1:0]       out_row;
  logic [lwc_pkg::OUT_COL_W-1:0]   out_col;
  logic                            last_of_frame;

  modport source (
    output valid, pixel_out, out_row, out_col, last_of_frame,
    input  ready
  );

  modport sink (
    input  valid, pixel_out, out_row, out_col, last_of_frame,
    output ready
  );
endinterface

// ===== hw/rtl/log_window_convolution.sv =====
// Top level of the log window convolution block.
//
// Usage: req carries coefficient loads (req_type 0) and raster-order pixels
// (req_type 1). A pixel whose window lies fully inside the image gives one
// item on res, tagged with the window centre; border pixels and coefficient
// loads give none. last_of_frame marks the final interior result.
// image_width and image_height sit on the APB port at byte addresses 0 and 4;
// a write returns the position to the start of a frame.
// Throughput: one item per cycle on req while the pipeline is not stalled.
// Pipeline: a result appears on res after its pixel is taken and has passed
// the line buffer read, window shift, products in the column cells, column
// sums, window sum, then the clamp into the output register.
// Stall: while res holds an item that is not taken, the whole pipeline
// holds and req.ready is low; it reopens in the cycle res.ready is high.
// Reset: counters return to row 0, column 0, the kernel clears, registers
// go to 640 x 480. Line buffers need no clearing pass.
`timescale 1ns / 1ps
`include "log_window_convolution_assert.svh"

module log_window_convolution #(
  parameter int WINDOW_SIZE = lwc_pkg::DEF_WINDOW_SIZE,
  parameter int MAX_WIDTH   = lwc_pkg::DEF_MAX_WIDTH,
  parameter int FRAC_BITS   = lwc_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  lwc_req_if.sink                         req,
  lwc_res_if.source                       res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lwc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [lwc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [lwc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int HALF   = WINDOW_SIZE / 2;
  localparam int CNT_W  = $clog2(MAX_WIDTH);
  localparam int EW     = $clog2(MAX_WIDTH + 1);
  localparam int LINE_W = (WINDOW_SIZE - 1) * lwc_pkg::PIX_W;
  localparam int COL_W  = lwc_pkg::PROD_W + $clog2(WINDOW_SIZE);
  localparam int ACC_W  = COL_W + $clog2(WINDOW_SIZE);
  localparam int ROW_W  = lwc_pkg::ROW_W;

  logic [lwc_pkg::CFG_W_W-1:0] width_reg;
  logic [lwc_pkg::CFG_H_W-1:0] height_reg;
  logic                        cfg_wr;

  logic [EW-1:0]    eff_w;
  logic [EW-1:0]    w_last;
  logic [ROW_W-1:0] eff_h;
  logic [ROW_W-1:0] h_last;

  logic [CNT_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic             at_col_last;
  logic             at_row_last;

  logic advance;
  logic acc_in;
  logic pix_acc;

  logic                               s1_valid;
  logic                               s1_pix;
  logic                               s1_produce;
  logic [lwc_pkg::PIX_W-1:0]          s1_pixel;
  logic [lwc_pkg::IDX_W-1:0]          s1_idx;
  logic signed [lwc_pkg::COEF_W-1:0]  s1_coef;
  logic [CNT_W-1:0]                   s1_addr;
  lwc_pkg::tag_t                      tag_in;
  lwc_pkg::tag_t                      s1_tag;
  lwc_pkg::tag_t                      s2_tag;
  lwc_pkg::tag_t                      s3_tag;
  lwc_pkg::tag_t                      s4_tag;
  lwc_pkg::tag_t                      s5_tag;
  logic                               s2_res;
  logic                               s3_res;
  logic                               s4_res;
  logic                               s5_res;

  logic [LINE_W-1:0]                          ram_q;
  logic [WINDOW_SIZE-1:0][lwc_pkg::PIX_W-1:0] new_col;
  logic [WINDOW_SIZE-1:0][lwc_pkg::PIX_W-1:0] cols [WINDOW_SIZE];
  logic signed [COL_W-1:0]                    sums [WINDOW_SIZE];
  lwc_pkg::ctrl_t                             ctrl;

  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_next;
  logic [lwc_pkg::PIX_W-1:0] pix_clamp;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      lwc_pkg::REG_WIDTH:  prdata = lwc_pkg::APB_DATA_W'(width_reg);
      lwc_pkg::REG_HEIGHT: prdata = lwc_pkg::APB_DATA_W'(height_reg);
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    if (int'(width_reg) < WINDOW_SIZE) begin
      eff_w = EW'(WINDOW_SIZE);
    end else if (int'(width_reg) > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_reg);
    end
    if (int'(height_reg) < WINDOW_SIZE) begin
      eff_h = ROW_W'(WINDOW_SIZE);
    end else begin
      eff_h = height_reg;
    end
  end

  assign w_last = eff_w - EW'(1);
  assign h_last = eff_h - ROW_W'(1);

  assign at_col_last = (EW'(col_cnt) == w_last);
  assign at_row_last = (row_cnt == h_last);

  // handshake
  assign advance   = !res.valid || res.ready;
  assign req.ready = advance;
  assign acc_in    = req.valid && advance;
  assign pix_acc   = acc_in && (req.req_type == lwc_pkg::REQ_PIXEL);

  always_comb begin
    tag_in.last = at_col_last && at_row_last;
    tag_in.row  = row_cnt - ROW_W'(HALF);
    tag_in.col  = lwc_pkg::OUT_COL_W'(col_cnt - CNT_W'(HALF));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= lwc_pkg::WIDTH_RESET;
      height_reg <= lwc_pkg::HEIGHT_RESET;
      col_cnt    <= '0;
      row_cnt    <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        lwc_pkg::REG_WIDTH:  width_reg  <= pwdata[lwc_pkg::CFG_W_W-1:0];
        lwc_pkg::REG_HEIGHT: height_reg <= pwdata[lwc_pkg::CFG_H_W-1:0];
        default:             width_reg  <= width_reg;
      endcase
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (pix_acc) begin
      if (at_col_last) begin
        col_cnt <= '0;
        row_cnt <= at_row_last ? '0 : row_cnt + ROW_W'(1);
      end else begin
        col_cnt <= col_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_res    <= 1'b0;
      s3_res    <= 1'b0;
      s4_res    <= 1'b0;
      s5_res    <= 1'b0;
      res.valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= acc_in;
      s2_res    <= s1_valid && s1_pix && s1_produce;
      s3_res    <= s2_res;
      s4_res    <= s3_res;
      s5_res    <= s4_res;
      res.valid <= s5_res;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (acc_in) begin
        s1_pix     <= (req.req_type == lwc_pkg::REQ_PIXEL);
        s1_produce <= (col_cnt >= CNT_W'(WINDOW_SIZE - 1)) &&
                      (row_cnt >= ROW_W'(WINDOW_SIZE - 1));
        s1_pixel   <= req.pixel_in;
        s1_idx     <= req.coef_index;
        s1_coef    <= req.coef_value;
        s1_addr    <= col_cnt;
        s1_tag     <= tag_in;
      end
      s2_tag            <= s1_tag;
      s3_tag            <= s2_tag;
      s4_tag            <= s3_tag;
      s5_tag            <= s4_tag;
      acc               <= acc_next;
      res.pixel_out     <= pix_clamp;
      res.out_row       <= s5_tag.row;
      res.out_col       <= s5_tag.col;
      res.last_of_frame <= s5_tag.last;
    end
  end

  // line buffers: one word per column, oldest line in the low byte
  lwc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (advance && s1_valid && s1_pix),
    .wr_addr (s1_addr),
    .wr_data (new_col[WINDOW_SIZE-1:1]),
    .rd_en   (pix_acc),
    .rd_addr (col_cnt),
    .rd_data (ram_q)
  );

  assign new_col = {s1_pixel, ram_q};

  always_comb begin
    ctrl.advance    = advance;
    ctrl.shift      = s1_valid && s1_pix;
    ctrl.coef_wr    = s1_valid && !s1_pix;
    ctrl.coef_index = s1_idx;
  end

  // window columns, newest on the right, shifting left
  for (genvar j = 0; j < WINDOW_SIZE; j++) begin : g_cell
    if (j == WINDOW_SIZE - 1) begin : g_head
      lwc_cell #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .COLUMN      (j)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .coef_value (s1_coef),
        .col_in     (new_col),
        .col_out    (cols[j]),
        .col_sum    (sums[j])
      );
    end else begin : g_body
      lwc_cell #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .COLUMN      (j)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .coef_value (s1_coef),
        .col_in     (cols[j+1]),
        .col_out    (cols[j]),
        .col_sum    (sums[j])
      );
    end
  end

  always_comb begin
    acc_next = '0;
    for (int j = 0; j < WINDOW_SIZE; j++) begin
      acc_next = acc_next + ACC_W'(sums[j]);
    end
  end

  always_comb begin
    if (acc[ACC_W-1]) begin
      pix_clamp = '0;
    end else if (|acc[ACC_W-2:FRAC_BITS+lwc_pkg::PIX_W]) begin
      pix_clamp = lwc_pkg::PIX_MAX;
    end else begin
      pix_clamp = acc[FRAC_BITS+lwc_pkg::PIX_W-1:FRAC_BITS];
    end
  end

  `LWC_ASSERT_NEXT(a_frame_wrap, clk, rst, pix_acc && !cfg_wr && at_col_last && at_row_last, (col_cnt == '0) && (row_cnt == '0), "position did not wrap at frame end")
  `LWC_ASSERT_IMPLIES(a_pos_range, clk, rst, 1'b1, (EW'(col_cnt) < eff_w) && (row_cnt < eff_h), "position outside the image")
  `LWC_ASSERT_NEXT(a_out_load, clk, rst, advance && s5_res, res.valid, "finished sum not loaded into output")
  `LWC_ASSERT_IMPLIES(a_last_pos, clk, rst, res.valid && res.last_of_frame, (res.out_col == lwc_pkg::OUT_COL_W'(w_last - EW'(HALF))) && (res.out_row == h_last - ROW_W'(HALF)), "frame end tag at wrong position")

endmodule

// ===== hw/rtl/lwc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/lwc_cell.sv =====
// Window column cell: one column of pixels, its kernel column and its partial sum.
`timescale 1ns / 1ps

module lwc_cell #(
  parameter int WINDOW_SIZE = lwc_pkg::DEF_WINDOW_SIZE,
  parameter int COLUMN      = 0
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  lwc_pkg::ctrl_t                                    ctrl,
  input  logic signed [lwc_pkg::COEF_W-1:0]                 coef_value,
  input  logic [WINDOW_SIZE-1:0][lwc_pkg::PIX_W-1:0]        col_in,
  output logic [WINDOW_SIZE-1:0][lwc_pkg::PIX_W-1:0]        col_out,
  output logic signed [lwc_pkg::PROD_W+$clog2(WINDOW_SIZE)-1:0] col_sum
);

  localparam int COL_W = lwc_pkg::PROD_W + $clog2(WINDOW_SIZE);

  logic [WINDOW_SIZE-1:0][lwc_pkg::PIX_W-1:0] pix;
  logic signed [lwc_pkg::COEF_W-1:0]          coef [WINDOW_SIZE];
  logic signed [lwc_pkg::PROD_W-1:0]          prod [WINDOW_SIZE];
  logic signed [COL_W-1:0]                    sum_next;

  assign col_out = pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        coef[i] <= '0;
      end
    end else if (ctrl.advance && ctrl.coef_wr) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        if (int'(ctrl.coef_index) == i * WINDOW_SIZE + COLUMN) begin
          coef[i] <= coef_value;
        end
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      sum_next = sum_next + COL_W'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      if (ctrl.shift) begin
        pix <= col_in;
      end
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        prod[i] <= $signed({1'b0, pix[i]}) * coef[i];
      end
      col_sum <= sum_next;
    end
  end

endmodule
